// ----- rtl/core/mrce_pkg.sv -----
// ----------------------------------------------------------------------------
// mrce_pkg: shared types and constants of the masked rectangle clear engine
// Surface geometry, store sizing and the controller/datapath link types.
// ----------------------------------------------------------------------------
package mrce_pkg;

  localparam int unsigned MaxWidth   = 128;
  localparam int unsigned MaxHeight  = 128;
  localparam int unsigned PixelBits  = 32;
  localparam int unsigned StoreDepth = MaxWidth * MaxHeight;
  localparam int unsigned AddrBits   = $clog2(StoreDepth);
  localparam int unsigned CoordBits  = 7;
  localparam int unsigned SizeBits   = 8;
  localparam int unsigned CfgBits    = 8;

  // configuration register indexes
  localparam logic CFG_BUFFER_WIDTH  = 1'b0;
  localparam logic CFG_BUFFER_HEIGHT = 1'b1;

  // command codes
  localparam logic FUNC_CLEAR = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef logic [PixelBits-1:0] pixel_t;
  typedef logic [AddrBits-1:0]  addr_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the accepted command
    logic start;     // set up the rectangle sweep
    logic step;      // read one pixel of the sweep and advance
    logic rd_pix;    // read the single addressed pixel
    logic out_load;  // load the result register
  } mrce_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;   // held command is a pixel read
    logic clr_any;   // held clear touches at least one pixel
    logic last;      // current sweep pixel is the final one
  } mrce_stat_t;

endpackage

// ----- rtl/core/mrce_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrce_ctrl: command sequencer
// Accepts one command, runs the clear sweep or the pixel read, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module mrce_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  mrce_pkg::mrce_stat_t stat_i,
  output mrce_pkg::mrce_cmd_t  cmd_o
);
  import mrce_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_RDWAIT = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.is_read) begin
          cmd_o.rd_pix = 1'b1;
          state_d      = ST_RDWAIT;
        end else if (stat_i.clr_any) begin
          cmd_o.start = 1'b1;
          state_d     = ST_CLEAR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      // final write-back of the sweep lands here
      ST_DRAIN:  state_d = ST_DONE;
      ST_RDWAIT: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/mrce_dp.sv -----
// ----------------------------------------------------------------------------
// mrce_dp: pixel store datapath
// Surface registers, clip logic, sweep counters, the pixel memory with its
// read-modify-write pipeline, and the result register.
// ----------------------------------------------------------------------------
module mrce_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [mrce_pkg::CfgBits-1:0]   cfg_data_i,
  input  logic                        func_i,
  input  logic [mrce_pkg::CoordBits-1:0] rect_x_i,
  input  logic [mrce_pkg::CoordBits-1:0] rect_y_i,
  input  logic [mrce_pkg::SizeBits-1:0]  rect_w_i,
  input  logic [mrce_pkg::SizeBits-1:0]  rect_h_i,
  input  mrce_pkg::pixel_t            fill_value_i,
  input  mrce_pkg::pixel_t            fill_mask_i,
  input  mrce_pkg::mrce_cmd_t         cmd_i,
  output mrce_pkg::mrce_stat_t        stat_o,
  output mrce_pkg::pixel_t            read_data_o,
  output logic                        was_read_o
);
  import mrce_pkg::*;

  localparam logic [CfgBits-1:0] MaxW = CfgBits'(MaxWidth);
  localparam logic [CfgBits-1:0] MaxH = CfgBits'(MaxHeight);

  // surface size registers
  logic [CfgBits-1:0] bw_q, bh_q;
  logic [CfgBits-1:0] bw_eff, bh_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= MaxW;
      bh_q <= MaxH;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_BUFFER_WIDTH) begin
        bw_q <= cfg_data_i;
      end else begin
        bh_q <= cfg_data_i;
      end
    end
  end

  assign bw_eff = (bw_q > MaxW) ? MaxW : bw_q;
  assign bh_eff = (bh_q > MaxH) ? MaxH : bh_q;

  // held command
  logic                 func_q;
  logic [CoordBits-1:0] x_q, y_q;
  logic [SizeBits-1:0]  w_q, h_q;
  pixel_t               keep_q, put_q;
  logic                 mask_nz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q    <= func_i;
      x_q       <= rect_x_i;
      y_q       <= rect_y_i;
      w_q       <= rect_w_i;
      h_q       <= rect_h_i;
      keep_q    <= ~fill_mask_i;
      put_q     <= fill_value_i & fill_mask_i;
      mask_nz_q <= (fill_mask_i != '0);
    end
  end

  // clip the rectangle to the surface
  logic [SizeBits:0]   x_sum, y_sum;
  logic [SizeBits-1:0] x_end, y_end;
  logic                in_surf;

  assign x_sum   = {2'b00, x_q} + {1'b0, w_q};
  assign y_sum   = {2'b00, y_q} + {1'b0, h_q};
  assign x_end   = (x_sum > {1'b0, bw_eff}) ? bw_eff : x_sum[SizeBits-1:0];
  assign y_end   = (y_sum > {1'b0, bh_eff}) ? bh_eff : y_sum[SizeBits-1:0];
  assign in_surf = ({1'b0, x_q} < bw_eff) && ({1'b0, y_q} < bh_eff);

  // one multiplier serves both the read address and the sweep's first row
  logic [CoordBits+CfgBits-1:0] row_prod;
  addr_t                        row_start;
  addr_t                        pix_addr;

  assign row_prod  = y_q * bw_eff;
  assign row_start = row_prod[AddrBits-1:0];
  assign pix_addr  = row_start + AddrBits'(x_q);

  // sweep counters
  logic [CoordBits-1:0] col_q, row_q;
  addr_t                row_base_q;
  logic [SizeBits-1:0]  col_next, row_next;
  logic                 row_wrap;
  addr_t                sweep_addr;

  assign col_next   = {1'b0, col_q} + 1'b1;
  assign row_next   = {1'b0, row_q} + 1'b1;
  assign row_wrap   = (col_next == x_end);
  assign sweep_addr = row_base_q + AddrBits'(col_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      col_q      <= x_q;
      row_q      <= y_q;
      row_base_q <= row_start;
    end else if (cmd_i.step) begin
      if (row_wrap) begin
        col_q      <= x_q;
        row_q      <= row_next[CoordBits-1:0];
        row_base_q <= row_base_q + AddrBits'(bw_eff);
      end else begin
        col_q <= col_next[CoordBits-1:0];
      end
    end
  end

  assign stat_o.is_read = (func_q == FUNC_READ);
  assign stat_o.clr_any = mask_nz_q && in_surf &&
                          ({1'b0, x_q} < x_end) && ({1'b0, y_q} < y_end);
  assign stat_o.last    = row_wrap && (row_next == y_end);

  // pixel memory: read one beat, write it back modified the next cycle
  pixel_t mem_q [StoreDepth];
  pixel_t rd_data_q;
  logic   rd_en;
  addr_t  rd_addr;
  logic   wr_pend_q;
  addr_t  wr_addr_q;

  assign rd_en   = cmd_i.step || cmd_i.rd_pix;
  assign rd_addr = cmd_i.rd_pix ? pix_addr : sweep_addr;

  always_ff @(posedge clk_i) begin
    if (wr_pend_q) begin
      mem_q[wr_addr_q] <= (rd_data_q & keep_q) | put_q;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      wr_addr_q <= sweep_addr;
    end
  end

  // result register
  pixel_t out_data_q;
  logic   out_read_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_read_q <= (func_q == FUNC_READ);
      out_data_q <= ((func_q == FUNC_READ) && in_surf) ? rd_data_q : '0;
    end
  end

  assign read_data_o = out_data_q;
  assign was_read_o  = out_read_q;

endmodule

// ----- rtl/core/masked_rect_clear_engine.sv -----
// ----------------------------------------------------------------------------
// masked_rect_clear_engine: masked rectangle clear over a pixel store
// A clear command sweeps the clipped rectangle one pixel per cycle, merging
// value and mask into each stored pixel; a read command returns one pixel.
// Exactly one result beat comes back per command.
//
// Sweep: a clear steps through a clipped W by H rectangle, doing one
// read-modify-write per pixel through the single write port of the pixel
// memory, then lands the final write-back. A read, or a clear that touches
// nothing, skips the sweep and goes on to the result. One command is in flight
// at a time; the next is accepted while the previous result waits to be
// taken. The store is not cleared at reset: clear the surface with a full
// mask before any partial-mask clear or read.
// ----------------------------------------------------------------------------
module masked_rect_clear_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [mrce_pkg::CfgBits-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [mrce_pkg::CoordBits-1:0] rect_x_i,
  input  logic [mrce_pkg::CoordBits-1:0] rect_y_i,
  input  logic [mrce_pkg::SizeBits-1:0]  rect_w_i,
  input  logic [mrce_pkg::SizeBits-1:0]  rect_h_i,
  input  mrce_pkg::pixel_t              fill_value_i,
  input  mrce_pkg::pixel_t              fill_mask_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mrce_pkg::pixel_t              read_data_o,
  output logic                          was_read_o
);
  import mrce_pkg::*;

  mrce_cmd_t  cmd;
  mrce_stat_t stat;

  mrce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mrce_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (func_i),
    .rect_x_i     (rect_x_i),
    .rect_y_i     (rect_y_i),
    .rect_w_i     (rect_w_i),
    .rect_h_i     (rect_h_i),
    .fill_value_i (fill_value_i),
    .fill_mask_i  (fill_mask_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .read_data_o  (read_data_o),
    .was_read_o   (was_read_o)
  );

endmodule

// ----- tb/masked_rect_clear_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_rect_clear_engine_tb: self-checking bench for the masked rect clear
// A queue-fed driver sends clear and read commands with random gaps. A monitor
// keeps its own copy of the pixel surface, predicts every result beat and
// compares it field by field. Surface size is changed between phases while the
// engine is idle.
// ----------------------------------------------------------------------------
module masked_rect_clear_engine_tb;
  import mrce_pkg::*;

  typedef struct {
    logic                 func;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [SizeBits-1:0]  w;
    logic [SizeBits-1:0]  h;
    pixel_t               value;
    pixel_t               mask;
  } surf_cmd_t;

  typedef struct {
    pixel_t data;
    logic   was_read;
  } answer_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic                 cfg_index_i  = CFG_BUFFER_WIDTH;
  logic [CfgBits-1:0]   cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic                 func_i       = FUNC_CLEAR;
  logic [CoordBits-1:0] rect_x_i     = '0;
  logic [CoordBits-1:0] rect_y_i     = '0;
  logic [SizeBits-1:0]  rect_w_i     = '0;
  logic [SizeBits-1:0]  rect_h_i     = '0;
  pixel_t               fill_value_i = '0;
  pixel_t               fill_mask_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  pixel_t               read_data_o;
  logic                 was_read_o;

  // bench copy of the engine state
  pixel_t             surface [StoreDepth];
  logic [CfgBits-1:0] surf_w_reg = 8'd128;
  logic [CfgBits-1:0] surf_h_reg = 8'd128;

  surf_cmd_t   cmd_q[$];
  answer_t     answer_q[$];
  int unsigned cmds_left    = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned cycle_count  = 0;
  int unsigned cycle_budget = 20000;
  int unsigned errors       = 0;
  logic        in_taken     = 1'b0;
  logic        idle_on      = 1'b1;

  masked_rect_clear_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .rect_x_i     (rect_x_i),
    .rect_y_i     (rect_y_i),
    .rect_w_i     (rect_w_i),
    .rect_h_i     (rect_h_i),
    .fill_value_i (fill_value_i),
    .fill_mask_i  (fill_mask_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .was_read_o   (was_read_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned clip_dim(logic [CfgBits-1:0] v, int unsigned lim);
    return (32'(v) > lim) ? lim : 32'(v);
  endfunction

  // mostly no gap, some short ones, a few long; never a gap while idle_on is low
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic surf_cmd_t make_clear(int unsigned x, int unsigned y, int unsigned w,
                                           int unsigned h, pixel_t value, pixel_t mask);
    surf_cmd_t c;
    c.func  = FUNC_CLEAR;
    c.x     = CoordBits'(x);
    c.y     = CoordBits'(y);
    c.w     = SizeBits'(w);
    c.h     = SizeBits'(h);
    c.value = value;
    c.mask  = mask;
    return c;
  endfunction

  function automatic surf_cmd_t make_read(int unsigned x, int unsigned y);
    surf_cmd_t c;
    c       = make_clear(x, y, $urandom_range(0, 128), $urandom_range(0, 128),
                         $urandom(), $urandom());
    c.func  = FUNC_READ;
    return c;
  endfunction

  // apply one command to the bench surface and queue the answer it yields
  task automatic run_surface_cmd(surf_cmd_t c);
    int unsigned bw, bh, x0, y0, x1, y1, idx;
    pixel_t      data;
    bw = clip_dim(surf_w_reg, MaxWidth);
    bh = clip_dim(surf_h_reg, MaxHeight);
    x0 = 32'(c.x);
    y0 = 32'(c.y);
    if (c.func == FUNC_READ) begin
      data = '0;
      if (x0 < bw && y0 < bh) begin
        idx = y0 * bw + x0;
        if (idx < StoreDepth) data = surface[idx];
      end
      answer_q.push_back('{data, 1'b1});
    end else begin
      if (c.mask != '0 && x0 < bw && y0 < bh) begin
        x1 = x0 + 32'(c.w);
        y1 = y0 + 32'(c.h);
        if (x1 > bw) x1 = bw;
        if (y1 > bh) y1 = bh;
        for (int unsigned r = y0; r < y1; r++) begin
          for (int unsigned col = x0; col < x1; col++) begin
            idx = r * bw + col;
            if (idx < StoreDepth) surface[idx] = (surface[idx] & ~c.mask) | (c.value & c.mask);
          end
        end
      end
      answer_q.push_back('{'0, 1'b0});
    end
  endtask

  function automatic surf_cmd_t rand_cmd();
    surf_cmd_t   c;
    int unsigned bw, bh, roll;
    bw = clip_dim(surf_w_reg, MaxWidth);
    bh = clip_dim(surf_h_reg, MaxHeight);
    c.func = ($urandom_range(0, 99) < 30) ? FUNC_READ : FUNC_CLEAR;
    c.x = CoordBits'((bw > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, bw - 1)
                                                             : $urandom_range(0, 127));
    c.y = CoordBits'((bh > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, bh - 1)
                                                             : $urandom_range(0, 127));
    // keep most rectangles small so the sweep stays short
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      c.w = SizeBits'($urandom_range(64, 128));
      c.h = SizeBits'($urandom_range(64, 128));
    end else if (roll < 12) begin
      c.w = SizeBits'($urandom_range(0, 128));
      c.h = SizeBits'($urandom_range(0, 3));
    end else if (roll < 20) begin
      c.w = SizeBits'($urandom_range(0, 3));
      c.h = SizeBits'($urandom_range(0, 128));
    end else begin
      c.w = SizeBits'($urandom_range(0, 8));
      c.h = SizeBits'($urandom_range(0, 8));
    end
    roll = $urandom_range(0, 99);
    if (roll < 35)      c.mask = '1;
    else if (roll < 45) c.mask = '0;
    else if (roll < 55) c.mask = pixel_t'(1) << $urandom_range(0, PixelBits - 1);
    else                c.mask = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 10)      c.value = '0;
    else if (roll < 20) c.value = '1;
    else                c.value = $urandom();
    return c;
  endfunction

  task automatic send_cmd(surf_cmd_t c);
    int unsigned area;
    area = (c.func == FUNC_CLEAR) ? 32'(c.w) * 32'(c.h) : 0;
    cycle_budget += 4 * (area + 100);
    cmds_left++;
    cmd_q.push_back(c);
  endtask

  task automatic wait_idle();
    while (cmds_left != 0 || answer_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_surface(int unsigned width, int unsigned height);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BUFFER_WIDTH;
    cfg_data_i  <= CfgBits'(width);
    @(negedge clk_i);
    cfg_index_i <= CFG_BUFFER_HEIGHT;
    cfg_data_i  <= CfgBits'(height);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // command driver
  always @(negedge clk_i) begin
    surf_cmd_t nxt;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        nxt          = cmd_q.pop_front();
        in_valid_i   <= 1'b1;
        func_i       <= nxt.func;
        rect_x_i     <= nxt.x;
        rect_y_i     <= nxt.y;
        rect_w_i     <= nxt.w;
        rect_h_i     <= nxt.h;
        fill_value_i <= nxt.value;
        fill_mask_i  <= nxt.mask;
        send_gap     = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // predictor and result checker
  always @(posedge clk_i) begin
    surf_cmd_t got_cmd;
    answer_t   want;
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("masked_rect_clear_engine regression: fail");
      $finish;
    end else begin
      in_taken <= rst_ni && in_valid_i && !in_stall_o;
      if (rst_ni) begin
        if (cfg_we_i) begin
          if (cfg_index_i == CFG_BUFFER_WIDTH) surf_w_reg = cfg_data_i;
          else                                 surf_h_reg = cfg_data_i;
        end
        if (in_valid_i && !in_stall_o) begin
          got_cmd = '{func_i, rect_x_i, rect_y_i, rect_w_i, rect_h_i,
                      fill_value_i, fill_mask_i};
          run_surface_cmd(got_cmd);
          cmds_left--;
        end
        if (out_valid_o && !out_stall_i) begin
          if (answer_q.size() == 0) begin
            $error("result beat with no command outstanding");
            errors++;
          end else begin
            want = answer_q.pop_front();
            if (read_data_o !== want.data) begin
              $error("read_data: expected %h, got %h", want.data, read_data_o);
              errors++;
            end
            if (was_read_o !== want.was_read) begin
              $error("was_read: expected %b, got %b", want.was_read, was_read_o);
              errors++;
            end
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // full-mask clear of the whole store first, so every entry is defined
    send_cmd(make_clear(0, 0, 128, 128, 32'hC3A5_5A3C, '1));
    send_cmd(make_read(0, 0));
    send_cmd(make_clear(127, 127, 128, 128, 32'h0000_0000, 32'h0000_0000));
    send_cmd(make_read(127, 127));
    // rectangle running past both edges, partial mask
    send_cmd(make_clear(120, 125, 128, 128, '1, 32'h0000_FFFF));
    send_cmd(make_read(127, 127));
    send_cmd(make_clear(3, 3, 0, 9, '1, '1));
    send_cmd(make_clear(3, 3, 9, 0, '1, '1));
    send_cmd(make_clear(2, 2, 4, 4, '1, '0));
    send_cmd(make_read(3, 3));
    send_cmd(make_clear(10, 20, 5, 3, 32'h1234_5678, 32'hF0F0_0F0F));
    send_cmd(make_read(12, 21));
    send_cmd(make_read(15, 21));
    wait_idle();

    // empty surface: nothing changes, reads give zero
    write_surface(0, 128);
    send_cmd(make_clear(0, 0, 128, 128, '0, '1));
    send_cmd(make_read(0, 0));
    wait_idle();
    write_surface(128, 0);
    send_cmd(make_read(5, 0));
    wait_idle();

    // oversized registers saturate
    write_surface(255, 200);
    send_cmd(make_read(127, 127));
    send_cmd(make_clear(100, 100, 128, 128, 32'h8000_0001, '1));
    send_cmd(make_read(127, 127));
    wait_idle();

    write_surface(1, 1);
    send_cmd(make_clear(0, 0, 1, 1, 32'h7FFF_FFFE, '1));
    send_cmd(make_read(0, 0));
    send_cmd(make_read(1, 0));
    send_cmd(make_read(0, 1));
    wait_idle();

    // new width re-addresses old entries without moving them
    write_surface(100, 37);
    send_cmd(make_clear(99, 36, 1, 1, 32'h5555_AAAA, '1));
    send_cmd(make_read(99, 36));
    send_cmd(make_read(0, 1));
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       write_surface(128, 128);
        1:       write_surface($urandom_range(1, 128), $urandom_range(1, 128));
        2:       write_surface(1, $urandom_range(2, 128));
        3:       write_surface($urandom_range(129, 255), $urandom_range(1, 255));
        default: write_surface($urandom_range(1, 16), $urandom_range(1, 16));
      endcase
      idle_on = (p != 1);
      for (int k = 0; k < 15; k++) begin
        send_cmd(rand_cmd());
        // hold the sender until the engine has drained
        if (p == 2 && k == 7) wait_idle();
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("masked_rect_clear_engine regression: pass");
    end else begin
      $display("masked_rect_clear_engine regression: fail");
    end
    $finish;
  end

endmodule
